@@ design/atg_pkg.sv @@
// Shared types and constants of the axis tick generator.
// No dependencies; every other design file imports this package.
package atg_pkg;

  localparam int unsigned FracDigits = 6;
  localparam int unsigned GapDivisor = 3;
  localparam int unsigned MaxTicks   = 16;

  localparam int unsigned VW  = 48;              // field width of limits and ticks
  localparam int unsigned W   = 56;              // internal signed datapath width
  localparam int unsigned DVW = VW + 1;          // dividend width of the divider
  localparam int unsigned CW  = $clog2(DVW + 1); // divider step counter width
  localparam int unsigned KW  = $clog2(MaxTicks);

  localparam logic signed [W-1:0] GAP_DIV_W = W'(GapDivisor);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [2:0] ADDR_SCALE_MODE = 3'd0;

  typedef struct packed {
    logic signed [VW-1:0] limit_min;
    logic signed [VW-1:0] limit_max;
  } in_t;

  typedef struct packed {
    logic signed [VW-1:0] tick_value;
    logic [KW-1:0]        tick_index;
    logic [1:0]           status;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       dec_step;
    logic       set_gap;
    logic       set_first;
    logic       logp_step;
    logic       emit_tick;
    logic       emit_stat;
    logic [1:0] stat_code;
  } atg_cmd_t;

  typedef struct packed {
    logic lin;
    logic illegal;
    logic div_busy;
    logic dec_more;
    logic logp_more;
    logic above;
    logic last;
    logic out_free;
  } atg_sts_t;

endpackage

@@ design/atg_div.sv @@
// Restoring divider, one quotient bit per cycle; only the remainder is used.
// Depends on atg_pkg for widths.
module atg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [atg_pkg::DVW-1:0]   dividend_i,
  input  logic [atg_pkg::W-1:0]     divisor_i,
  output logic                      busy_o,
  output logic [atg_pkg::W-1:0]     rem_o
);
  import atg_pkg::*;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [DVW-1:0] sh_q, sh_d;
  logic [W-1:0]   rem_q, rem_d;
  logic [W-1:0]   trial;

  always_comb begin
    cnt_d = cnt_q;
    sh_d  = sh_q;
    rem_d = rem_q;
    trial = {rem_q[W-2:0], sh_q[DVW-1]};
    if (start_i) begin
      cnt_d = CW'(DVW);
      sh_d  = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
      if (trial >= divisor_i) begin
        rem_d = trial - divisor_i;
        sh_d  = {sh_q[DVW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        sh_d  = {sh_q[DVW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule

@@ design/atg_dp.sv @@
// Datapath: limits, decade and gap search, first tick, tick stepping, output register.
// Depends on atg_pkg and atg_div.
module atg_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_i,
  input  atg_pkg::in_t      in_data_i,
  input  atg_pkg::atg_cmd_t cmd_i,
  output atg_pkg::atg_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output atg_pkg::out_t     out_data_o
);
  import atg_pkg::*;

  logic signed [W-1:0] lo_q, hi_q, v_q, dec_q, gap_q;
  logic [KW-1:0]       k_q;
  logic                out_valid_q;
  out_t                out_q;

  logic signed [W-1:0] span, lo_abs, rem, dec10, dec5, dec2, v_next, first;
  logic signed [W-1:0] dec10_n, dec5_n, dec2_n;
  logic [DVW-1:0]      dividend;
  logic [W-1:0]        divisor, rem_u;
  logic                busy, last;

  assign span     = hi_q - lo_q;
  assign lo_abs   = lo_q[W-1] ? -lo_q : lo_q;
  assign dividend = lo_abs[DVW-1:0];
  assign divisor  = gap_q;

  atg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (busy),
    .rem_o      (rem_u)
  );

  assign rem   = rem_u;
  assign dec10 = (dec_q <<< 3) + (dec_q <<< 1);
  assign dec5  = (dec_q <<< 2) + dec_q;
  assign dec2  = dec_q <<< 1;

  // compare the span against divisor multiples instead of dividing it
  assign dec10_n = dec10 * GAP_DIV_W;
  assign dec5_n  = (dec5 + W'(1)) * GAP_DIV_W;
  assign dec2_n  = (dec2 + W'(1)) * GAP_DIV_W;

  always_comb begin
    if (lo_q[W-1]) begin
      first = lo_q + rem;
    end else if (rem == '0) begin
      first = lo_q;
    end else begin
      first = lo_q - rem + gap_q;
    end
  end

  assign v_next = mode_i ? ((v_q <<< 3) + (v_q <<< 1)) : (v_q + gap_q);
  assign last   = (k_q == KW'(MaxTicks - 1)) || (v_next > hi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q  <= W'(in_data_i.limit_min);
      hi_q  <= W'(in_data_i.limit_max);
      dec_q <= W'(1);
      v_q   <= W'(1);
      k_q   <= '0;
    end else begin
      if (cmd_i.dec_step) begin
        dec_q <= dec10;
      end
      if (cmd_i.set_gap) begin
        if (span >= dec5_n) begin
          gap_q <= dec5;
        end else if (span >= dec2_n) begin
          gap_q <= dec2;
        end else begin
          gap_q <= dec_q;
        end
      end
      if (cmd_i.set_first) begin
        v_q <= first;
      end
      if (cmd_i.logp_step || cmd_i.emit_tick) begin
        v_q <= v_next;
      end
      if (cmd_i.emit_tick) begin
        k_q <= k_q + KW'(1);
      end
    end
    if (cmd_i.emit_tick) begin
      out_q.tick_value <= v_q[VW-1:0];
      out_q.tick_index <= k_q;
      out_q.status     <= ST_OK;
      out_q.last       <= last;
    end else if (cmd_i.emit_stat) begin
      out_q.tick_value <= '0;
      out_q.tick_index <= '0;
      out_q.status     <= cmd_i.stat_code;
      out_q.last       <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_tick || cmd_i.emit_stat) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.lin       = !mode_i;
  assign sts_o.illegal   = mode_i ? ((lo_q <= 0) || (hi_q <= 0)) : (hi_q <= lo_q);
  assign sts_o.div_busy  = busy;
  assign sts_o.dec_more  = (span >= dec10_n);
  assign sts_o.logp_more = (v_q < lo_q);
  assign sts_o.above     = (v_q > hi_q);
  assign sts_o.last      = last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/atg_ctrl.sv @@
// Controller state machine sequencing the tick search and the emission of beats.
// Depends on atg_pkg for command and status structs.
module atg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  atg_pkg::atg_sts_t sts_i,
  output atg_pkg::atg_cmd_t cmd_o
);
  import atg_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_GAP   = 4'd4;
  localparam logic [3:0] S_DIVS  = 4'd5;
  localparam logic [3:0] S_DIVR  = 4'd6;
  localparam logic [3:0] S_LOGP  = 4'd7;
  localparam logic [3:0] S_TEST  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_ILL   = 4'd10;
  localparam logic [3:0] S_NONE  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.illegal) begin
          state_d = S_ILL;
        end else if (sts_i.lin) begin
          state_d = S_DEC;
        end else begin
          state_d = S_LOGP;
        end
      end
      S_DEC: begin
        if (sts_i.dec_more) begin
          cmd_o.dec_step = 1'b1;
        end else begin
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        cmd_o.set_gap = 1'b1;
        state_d       = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVR;
      end
      S_DIVR: begin
        if (!sts_i.div_busy) begin
          cmd_o.set_first = 1'b1;
          state_d         = S_TEST;
        end
      end
      S_LOGP: begin
        if (sts_i.logp_more) begin
          cmd_o.logp_step = 1'b1;
        end else begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        state_d = sts_i.above ? S_NONE : S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_tick = 1'b1;
          if (sts_i.last) state_d = S_IDLE;
        end
      end
      S_ILL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat_code = ST_ILLEGAL;
          state_d         = S_IDLE;
        end
      end
      S_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat_code = ST_NONE;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ design/axis_tick_generator.sv @@
// Top level of the axis tick generator: APB register, controller and datapath.
// Depends on atg_pkg, atg_ctrl and atg_dp.
//
// One request (low and high limit) yields a run of up to 16 tick beats, or a single
// status beat, with last on the final one. Requests are handled one at a time.
// In linear mode a taken request passes through the check state, the decade search,
// gap choice, divider start, the one-bit-per-cycle remainder divide that sets the
// first tick, and the test state; then one tick beat per cycle while the output is
// not stalled. In log mode the check is followed by the search for the first power
// of ten at or above the low limit, then the test state. An illegal request gives
// its status beat after the check state, once the output is free.
module axis_tick_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  atg_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output atg_pkg::out_t out_data_o
);
  import atg_pkg::*;

  logic     mode_q;
  atg_cmd_t cmd;
  atg_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_SCALE_MODE[2])) begin
      mode_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_SCALE_MODE[2]) ? {31'd0, mode_q} : 32'd0;

  atg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  atg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ design/atg_checker.sv @@
// Port-level checks of the axis tick generator, bound to the top level.
// Depends on atg_pkg.
module atg_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input atg_pkg::out_t out_data_o
);
  import atg_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      out_data_o.last && (out_data_o.tick_value == '0) && (out_data_o.tick_index == '0))
    else $error("status beat not a lone zero beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in work");

endmodule

bind axis_tick_generator atg_checker u_atg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
